// File: hw/rtl/sine_triangle_waveform_generator_core_assert.svh
// Assertion macros for the waveform generator core.
`ifndef SINE_TRIANGLE_WAVEFORM_GENERATOR_CORE_ASSERT_SVH
`define SINE_TRIANGLE_WAVEFORM_GENERATOR_CORE_ASSERT_SVH

// Clocked on aclk, disabled while aresetn is low.
`define STWG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked on aclk, also checked during reset.
`define STWG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hw/rtl/stwg_pkg.sv
// Package: register codes and fixed constants of the waveform generator.
`timescale 1ns / 1ps
package stwg_pkg;

    localparam int TIME_BITS   = 32;
    localparam int PMS_BITS    = 23;
    localparam int AMP_BITS    = 13;
    localparam int OFS_BITS    = 12;
    localparam int CFG_W       = 23;
    localparam int PER_BITS    = 33;
    localparam int W_BITS      = 17;
    localparam int T_BITS      = 32;

    localparam logic [9:0] PERIOD_SCALE = 10'd1000;

    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
    localparam int Q15_ONE = 32768;
    localparam int Q15_MAX = 32767;
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef enum logic [1:0] {
        CFG_WAVE_MODE = 2'd0,
        CFG_PERIOD_MS = 2'd1,
        CFG_AMPLITUDE = 2'd2,
        CFG_OFFSET    = 2'd3
    } cfg_idx_t;

    localparam logic [PMS_BITS-1:0] RST_PERIOD_MS = 23'd1000;
    localparam logic [AMP_BITS-1:0] RST_AMPLITUDE = 13'd1600;
    localparam logic [OFS_BITS-1:0] RST_OFFSET    = 12'd2048;

endpackage

// File: hw/rtl/sine_triangle_waveform_generator_core.sv
// Sine / triangle waveform generator: timestamp in, saturated DAC code out.
// Unless stalled, one transaction is accepted per cycle; results keep their order.
// The pipeline is a chain of restoring divider stages (32 for time modulo
// period, PHASE_BITS for the phase fraction), one bit per stage, then wave
// select, table read, scaling and round/saturate. Backpressure on m_ready
// holds the whole pipeline. Configuration must be written while idle (the
// block does not enforce it); the period product is registered the next cycle.
`timescale 1ns / 1ps
module sine_triangle_waveform_generator_core #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 16,
    parameter int DAC_BITS         = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  stwg_pkg::cfg_idx_t              cfg_addr,
    input  logic [stwg_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [stwg_pkg::TIME_BITS-1:0]  s_time_us,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [DAC_BITS-1:0]             m_dac_code,
    output logic                            m_clipped
);
    import stwg_pkg::*;

    `include "sine_triangle_waveform_generator_core_assert.svh"

    localparam int NSTG  = TIME_BITS + PHASE_BITS;
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int POS_W = PHASE_BITS - 2;
    localparam int MUL_W = POS_W + IDX_W;
    localparam int TRI_W = PHASE_BITS + 17;
    localparam logic signed [T_BITS-1:0] CODE_MAX = T_BITS'((1 << DAC_BITS) - 1);

    typedef logic [15:0] lut_t [0:SINE_TABLE_DEPTH];

    function automatic lut_t build_lut();
        lut_t tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] q;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x = (HALFPI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
            term = x;
            sum = $signed(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / TAYLOR_DIV[n-1];
                if (n % 2 == 1) sum = sum - $signed(term);
                else sum = sum + $signed(term);
            end
            if (sum < 0) sum = 0;
            q = (64'(sum) + 64'd16384) >> 15;
            if (q > 64'(Q15_MAX)) q = 64'(Q15_MAX);
            tab[k] = q[15:0];
        end
        return tab;
    endfunction

    localparam lut_t SINE_LUT = build_lut();

    // configuration
    logic                 mode_reg;
    logic [PER_BITS-1:0]  per_reg;
    logic [PMS_BITS-1:0]  pms_reg;
    logic signed [AMP_BITS-1:0] amp_reg;
    logic [OFS_BITS-1:0]  ofs_reg;
    logic [PMS_BITS-1:0]  pms_eff;

    assign pms_eff = (pms_reg == '0) ? PMS_BITS'(1) : pms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            pms_reg  <= RST_PERIOD_MS;
            amp_reg  <= RST_AMPLITUDE;
            ofs_reg  <= RST_OFFSET;
            per_reg  <= PER_BITS'(RST_PERIOD_MS) * PER_BITS'(PERIOD_SCALE);
        end else begin
            per_reg <= PER_BITS'(pms_eff) * PER_BITS'(PERIOD_SCALE);
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_WAVE_MODE: mode_reg <= cfg_wdata[0];
                    CFG_PERIOD_MS: pms_reg  <= cfg_wdata[PMS_BITS-1:0];
                    CFG_AMPLITUDE: amp_reg  <= cfg_wdata[AMP_BITS-1:0];
                    CFG_OFFSET:    ofs_reg  <= cfg_wdata[OFS_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // restoring divider chain
    logic                  v_reg    [NSTG];
    logic [PER_BITS-1:0]   rem_reg  [NSTG];
    logic [TIME_BITS-1:0]  tb_reg   [NSTG];
    logic [PHASE_BITS-1:0] q_reg    [NSTG];
    logic                  v_next   [NSTG];
    logic [PER_BITS-1:0]   rem_next [NSTG];
    logic [TIME_BITS-1:0]  tb_next  [NSTG];
    logic [PHASE_BITS-1:0] q_next   [NSTG];

    always_comb begin
        logic [PER_BITS:0]     cand;
        logic [PER_BITS-1:0]   rin;
        logic [TIME_BITS-1:0]  tin;
        logic [PHASE_BITS-1:0] qin;
        logic                  ge;
        for (int s = 0; s < NSTG; s++) begin
            if (s == 0) begin
                v_next[s] = s_valid;
                rin = '0;
                tin = s_time_us;
                qin = '0;
            end else begin
                v_next[s] = v_reg[s-1];
                rin = rem_reg[s-1];
                tin = tb_reg[s-1];
                qin = q_reg[s-1];
            end
            cand = {rin, (s < TIME_BITS) ? tin[TIME_BITS-1] : 1'b0};
            ge = cand >= {1'b0, per_reg};
            rem_next[s] = ge ? PER_BITS'(cand - {1'b0, per_reg}) : cand[PER_BITS-1:0];
            tb_next[s] = {tin[TIME_BITS-2:0], 1'b0};
            q_next[s] = (s < TIME_BITS) ? qin : {qin[PHASE_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NSTG; s++) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_next[s];
            end
            if (en) begin
                rem_reg[s] <= rem_next[s];
                tb_reg[s]  <= tb_next[s];
                q_reg[s]   <= q_next[s];
            end
        end
    end

    // wave select
    logic [PHASE_BITS-1:0] phase;
    logic [POS_W-1:0]      pos;
    logic [MUL_W-1:0]      pos_mul;
    logic [IDX_W-1:0]      idx;
    logic [PHASE_BITS:0]   twice;
    logic [PHASE_BITS:0]   tri_a;
    logic [TRI_W-1:0]      tri_wide;
    logic signed [17:0]    tri_s;

    assign phase    = q_reg[NSTG-1];
    assign pos      = phase[POS_W-1:0];
    assign pos_mul  = MUL_W'(pos) * MUL_W'(SINE_TABLE_DEPTH);
    assign idx      = IDX_W'(pos_mul >> POS_W);
    assign twice    = {phase, 1'b0};
    assign tri_a    = twice[PHASE_BITS] ? (twice - {1'b1, {PHASE_BITS{1'b0}}})
                                        : ({1'b1, {PHASE_BITS{1'b0}}} - twice);
    assign tri_wide = {tri_a, 16'b0} >> PHASE_BITS;
    assign tri_s    = $signed({1'b0, tri_wide[16:0]}) - 18'sd32768;

    logic                     a_v_reg;
    logic                     a_mode_reg;
    logic                     a_neg_reg;
    logic [IDX_W-1:0]         a_addr_reg;
    logic signed [W_BITS-1:0] a_tri_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= v_reg[NSTG-1];
        end
        if (en) begin
            a_mode_reg <= mode_reg;
            a_neg_reg  <= phase[PHASE_BITS-1];
            a_addr_reg <= phase[PHASE_BITS-2] ? IDX_W'(SINE_TABLE_DEPTH - int'(idx)) : idx;
            a_tri_reg  <= (tri_s > 18'sd32767) ? 17'sd32767 : W_BITS'(tri_s);
        end
    end

    // table read
    logic signed [W_BITS-1:0] sin_w;
    logic                     b_v_reg;
    logic signed [W_BITS-1:0] b_w_reg;

    assign sin_w = a_neg_reg ? -$signed({1'b0, SINE_LUT[a_addr_reg]})
                             : $signed({1'b0, SINE_LUT[a_addr_reg]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg <= a_v_reg;
        end
        if (en) b_w_reg <= a_mode_reg ? a_tri_reg : sin_w;
    end

    // scale and offset
    logic                     c_v_reg;
    logic signed [T_BITS-1:0] c_t_reg;
    logic signed [T_BITS-1:0] t_next;

    assign t_next = $signed({{(T_BITS-OFS_BITS-15){1'b0}}, ofs_reg, 15'b0})
                  + (T_BITS'(amp_reg) * T_BITS'(b_w_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (en) begin
            c_v_reg <= b_v_reg;
        end
        if (en) c_t_reg <= t_next;
    end

    // round half away from zero, saturate
    logic [T_BITS-1:0]        t_mag;
    logic [T_BITS-1:0]        r_mag;
    logic signed [T_BITS-1:0] r_val;

    assign t_mag = c_t_reg[T_BITS-1] ? T_BITS'(-c_t_reg) : T_BITS'(c_t_reg);
    assign r_mag = (t_mag + T_BITS'(16384)) >> 15;
    assign r_val = c_t_reg[T_BITS-1] ? -$signed(r_mag) : $signed(r_mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= c_v_reg;
        end
        if (en) begin
            if (r_val < 0) begin
                m_dac_code <= '0;
                m_clipped  <= 1'b1;
            end else if (r_val > CODE_MAX) begin
                m_dac_code <= DAC_BITS'(CODE_MAX);
                m_clipped  <= 1'b1;
            end else begin
                m_dac_code <= DAC_BITS'(r_val);
                m_clipped  <= 1'b0;
            end
        end
    end

    `STWG_ASSERT(a_clip_at_limit, m_valid && m_clipped |-> (m_dac_code == '0 || m_dac_code == DAC_BITS'(CODE_MAX)), "clip flag set away from a limit")
    `STWG_ASSERT(a_rem_below_per, v_reg[NSTG-1] |-> rem_reg[NSTG-1] < per_reg, "divider remainder not below period")
    `STWG_ASSERT(a_stall_holds, !s_ready |=> $stable(q_reg[NSTG-1]) && $stable(c_t_reg), "pipeline moved during stall")
    `STWG_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid && !a_v_reg, "valid survived reset")

endmodule
